// File: hw/rtl/assert_macros.svh
// Assertion macros used by the frame parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, and switched off while reset is held low.
`define ASSERT_CLK_RST(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Checked on every rising edge, including during reset.
`define ASSERT_CLK(name, clk, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/sltfp_pkg.sv
`default_nettype none

package sltfp_pkg;

    // Field widths.
    localparam int BYTE_W      = 8;
    localparam int LENGTH_W    = 30;
    localparam int TIMEOUT_W   = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    // Register reset values.
    localparam logic [BYTE_W-1:0]    FIRST_SYNC_RST    = 8'hA5;
    localparam logic [BYTE_W-1:0]    SECOND_SYNC_RST   = 8'h5A;
    localparam logic [BYTE_W-1:0]    EXPECTED_TYPE_RST = 8'h00;
    localparam logic [BYTE_W-1:0]    CAPTURE_LIMIT_RST = 8'd20;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_MS_RST    = 32'd1500;

    // Input operation codes.
    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_START = 2'd2
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_RUNNING  = 2'd0,
        ST_MATCHED  = 2'd1,
        ST_TIMEOUT  = 2'd2,
        ST_IGNORING = 2'd3
    } status_t;

    // Frame parser phases.
    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_TYPE    = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FIRST_SYNC    = 3'd0,
        CFG_SECOND_SYNC   = 3'd1,
        CFG_EXPECTED_TYPE = 3'd2,
        CFG_CAPTURE_LIMIT = 3'd3,
        CFG_TIMEOUT_MS    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [BYTE_W-1:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic              store_strobe;
        logic [BYTE_W-1:0] store_index;
        logic [BYTE_W-1:0] store_byte;
        logic [1:0]        status;
        logic [BYTE_W-1:0] matched_type;
    } out_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/sync_length_type_frame_parser.sv
// Reply-frame parser for a received byte stream. Each input transaction is a received byte,
// a one millisecond tick or a start command; each produces exactly one result transaction
// carrying an optional payload store strobe (index and byte), the transaction status
// (running, matched, timed out or ignoring) and the matched frame type. Frames are
// two sync bytes, a four-byte little-endian length whose top two bits are dropped, a type byte
// and the payload. The block takes one transaction per clock cycle at full rate unless the
// result channel stalls. Each transaction passes an input register and then a result register;
// its result is offered on the result channel once it enters the result register, when that
// register is free. The input register accepts a new transaction while a result still waits in
// the result register. Configuration registers are written through a plain write port and take
// effect at once. The user must write them only while the block is idle; nothing enforces it.
`default_nettype none
`include "assert_macros.svh"

module sync_length_type_frame_parser (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Input channel.
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire sltfp_pkg::in_item_t                  s_data,
    // Result channel.
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output sltfp_pkg::out_item_t                      m_data,
    // Configuration write port.
    input  wire logic                                 cfg_wr_en,
    input  wire logic [sltfp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [sltfp_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
    import sltfp_pkg::*;

    // Configuration registers.
    logic [BYTE_W-1:0]    first_sync_reg;
    logic [BYTE_W-1:0]    second_sync_reg;
    logic [BYTE_W-1:0]    expected_type_reg;
    logic [BYTE_W-1:0]    capture_limit_reg;
    logic [TIMEOUT_W-1:0] timeout_ms_reg;

    // Pipeline registers.
    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t result;
    logic      advance;

    // Parser state.
    phase_t               phase_reg, phase_next;
    logic [1:0]           len_cnt_reg, len_cnt_next;
    logic [LENGTH_W-1:0]  frame_len_reg, frame_len_next;
    logic [BYTE_W-1:0]    frame_type_reg, frame_type_next;
    logic [LENGTH_W-1:0]  pay_pos_reg, pay_pos_next;
    logic [TIMEOUT_W-1:0] elapsed_reg, elapsed_next;
    logic                 finished_reg, finished_next;

    // Shared decode of the transaction in the input register.
    logic [1:0]           in_op;
    logic [BYTE_W-1:0]    in_byte;
    logic [TIMEOUT_W-1:0] elapsed_inc;
    logic                 tick_timeout;
    logic                 byte_timeout;
    logic                 parse_en;
    logic [LENGTH_W-1:0]  len_byte_shifted;
    logic [LENGTH_W-1:0]  pay_pos_inc;
    logic                 pay_done;
    logic                 type_match_done;
    logic                 pay_match_done;
    logic                 matched_now;
    logic                 capture_hit;

    // Configuration writes; indexes beyond the register list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_sync_reg    <= FIRST_SYNC_RST;
            second_sync_reg   <= SECOND_SYNC_RST;
            expected_type_reg <= EXPECTED_TYPE_RST;
            capture_limit_reg <= CAPTURE_LIMIT_RST;
            timeout_ms_reg    <= TIMEOUT_MS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FIRST_SYNC:    first_sync_reg    <= cfg_wr_data[BYTE_W-1:0];
                CFG_SECOND_SYNC:   second_sync_reg   <= cfg_wr_data[BYTE_W-1:0];
                CFG_EXPECTED_TYPE: expected_type_reg <= cfg_wr_data[BYTE_W-1:0];
                CFG_CAPTURE_LIMIT: capture_limit_reg <= cfg_wr_data[BYTE_W-1:0];
                CFG_TIMEOUT_MS:    timeout_ms_reg    <= cfg_wr_data[TIMEOUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Handshake: the held transaction moves on when the result register is free.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= (s_valid && s_ready) || (in_valid_reg && !advance);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= advance || (out_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    // Decode of the held transaction against the parser state.
    assign in_op   = in_data_reg.operation;
    assign in_byte = in_data_reg.data_byte;

    assign elapsed_inc  = (elapsed_reg == {TIMEOUT_W{1'b1}}) ? elapsed_reg
                                                             : elapsed_reg + 1'b1;
    assign tick_timeout = elapsed_inc >= timeout_ms_reg;
    assign byte_timeout = elapsed_reg >= timeout_ms_reg;
    assign parse_en     = (in_op == OP_BYTE) && !finished_reg && !byte_timeout;

    assign len_byte_shifted = LENGTH_W'(LENGTH_W'(in_byte) << {len_cnt_reg, 3'b000});
    assign pay_pos_inc      = pay_pos_reg + 1'b1;
    assign pay_done         = pay_pos_inc >= frame_len_reg;

    assign type_match_done = (phase_reg == PH_TYPE) && (frame_len_reg == '0)
                          && (in_byte == expected_type_reg);
    assign pay_match_done  = (phase_reg == PH_PAYLOAD) && pay_done
                          && (frame_type_reg == expected_type_reg);
    assign matched_now     = parse_en && (type_match_done || pay_match_done);
    assign capture_hit     = parse_en && (phase_reg == PH_PAYLOAD)
                          && (pay_pos_reg < LENGTH_W'(capture_limit_reg));

    // Next state of the parser.
    always_comb begin
        phase_next      = phase_reg;
        len_cnt_next    = len_cnt_reg;
        frame_len_next  = frame_len_reg;
        frame_type_next = frame_type_reg;
        pay_pos_next    = pay_pos_reg;
        elapsed_next    = elapsed_reg;
        finished_next   = finished_reg;
        if (advance) begin
            if (in_op == OP_START) begin
                phase_next      = PH_SYNC1;
                len_cnt_next    = '0;
                frame_len_next  = '0;
                frame_type_next = '0;
                pay_pos_next    = '0;
                elapsed_next    = '0;
                finished_next   = 1'b0;
            end else if (finished_reg) begin
                // Everything but a start is ignored once finished.
            end else if (in_op == OP_TICK) begin
                elapsed_next = elapsed_inc;
                if (tick_timeout) begin
                    finished_next = 1'b1;
                end
            end else if (in_op == OP_BYTE) begin
                if (byte_timeout) begin
                    finished_next = 1'b1;
                end else begin
                    unique case (phase_reg)
                        PH_SYNC1: begin
                            if (in_byte == first_sync_reg) begin
                                phase_next = PH_SYNC2;
                            end
                        end
                        PH_SYNC2: begin
                            if (in_byte == second_sync_reg) begin
                                phase_next     = PH_LENGTH;
                                len_cnt_next   = '0;
                                frame_len_next = '0;
                            end else begin
                                phase_next = PH_SYNC1;
                            end
                        end
                        PH_LENGTH: begin
                            frame_len_next = frame_len_reg | len_byte_shifted;
                            len_cnt_next   = len_cnt_reg + 1'b1;
                            if (len_cnt_reg == 2'd3) begin
                                phase_next = PH_TYPE;
                            end
                        end
                        PH_TYPE: begin
                            frame_type_next = in_byte;
                            pay_pos_next    = '0;
                            if (frame_len_reg != '0) begin
                                phase_next = PH_PAYLOAD;
                            end else begin
                                phase_next = PH_SYNC1;
                                if (type_match_done) begin
                                    finished_next = 1'b1;
                                end
                            end
                        end
                        PH_PAYLOAD: begin
                            pay_pos_next = pay_pos_inc;
                            if (pay_done) begin
                                phase_next = PH_SYNC1;
                                if (pay_match_done) begin
                                    finished_next = 1'b1;
                                end else begin
                                    len_cnt_next    = '0;
                                    frame_len_next  = '0;
                                    frame_type_next = '0;
                                    pay_pos_next    = '0;
                                end
                            end
                        end
                        default: begin
                            phase_next      = PH_SYNC1;
                            len_cnt_next    = '0;
                            frame_len_next  = '0;
                            frame_type_next = '0;
                            pay_pos_next    = '0;
                        end
                    endcase
                end
            end
        end
    end

    // Result fields for the held transaction.
    always_comb begin
        result = '0;
        if (in_op == OP_START) begin
            result.status = ST_RUNNING;
        end else if (finished_reg) begin
            result.status = ST_IGNORING;
        end else if ((in_op == OP_TICK) && tick_timeout) begin
            result.status = ST_TIMEOUT;
        end else if ((in_op == OP_BYTE) && byte_timeout) begin
            result.status = ST_TIMEOUT;
        end else if (matched_now) begin
            result.status       = ST_MATCHED;
            result.matched_type = expected_type_reg;
        end else begin
            result.status = ST_RUNNING;
        end
        if (capture_hit) begin
            result.store_strobe = 1'b1;
            result.store_index  = pay_pos_reg[BYTE_W-1:0];
            result.store_byte   = in_byte;
        end
    end

    // Parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SYNC1;
            len_cnt_reg    <= '0;
            frame_len_reg  <= '0;
            frame_type_reg <= '0;
            pay_pos_reg    <= '0;
            elapsed_reg    <= '0;
            finished_reg   <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            len_cnt_reg    <= len_cnt_next;
            frame_len_reg  <= frame_len_next;
            frame_type_reg <= frame_type_next;
            pay_pos_reg    <= pay_pos_next;
            elapsed_reg    <= elapsed_next;
            finished_reg   <= finished_next;
        end
    end

    // A finished parser answers every non-start transaction with the ignoring status.
    `ASSERT_CLK_RST(a_ignore_after_finish, aclk, aresetn,
        (advance && finished_reg && (in_op != OP_START)) |=>
            (out_data_reg.status == ST_IGNORING))

    // A stored byte always lies below the capture limit.
    `ASSERT_CLK_RST(a_store_below_limit, aclk, aresetn,
        (out_valid_reg && out_data_reg.store_strobe) |->
            (out_data_reg.store_index < capture_limit_reg))

    // The length byte counter only moves while the length field is read.
    `ASSERT_CLK_RST(a_len_cnt_phase, aclk, aresetn,
        (len_cnt_reg != 2'd0) |-> (phase_reg == PH_LENGTH))

    // Inside a payload the position never reaches the frame length.
    `ASSERT_CLK_RST(a_payload_in_frame, aclk, aresetn,
        (phase_reg == PH_PAYLOAD) |-> (pay_pos_reg < frame_len_reg))

endmodule

`default_nettype wire
